[hw/rtl/ircs_pkg.sv]
package ircs_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 1024;
    localparam int COMPONENT_BITS = 16;

    localparam int TOTAL_W = 28;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 11;
    localparam int DIM_W   = 11;
    localparam int COMP_W  = 16;
    localparam int SUM_W   = COMPONENT_BITS + 2;
    localparam int FILL_W  = COL_W + 1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [1:0] KIND_PIXEL   = 2'd0;
    localparam logic [1:0] KIND_READ    = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    localparam logic [2:0] ST_ROW_DONE     = 3'd0;
    localparam logic [2:0] ST_ROW_MISMATCH = 3'd1;
    localparam logic [2:0] ST_RANGE        = 3'd2;
    localparam logic [2:0] ST_COLUMN       = 3'd3;
    localparam logic [2:0] ST_IMAGE_OK     = 3'd4;
    localparam logic [2:0] ST_TOO_MANY     = 3'd5;
    localparam logic [2:0] ST_IMAGE_BAD    = 3'd6;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MAXVAL = 2'd2;
    localparam logic [1:0] REG_CHECK  = 2'd3;

    localparam logic [DIM_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [DIM_W-1:0]  HEIGHT_RESET = 11'd480;
    localparam logic [COMP_W-1:0] MAXVAL_RESET = 16'd255;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [2:0]         status;
        logic [TOTAL_W-1:0] total;
        logic [COL_W-1:0]   row_number;
    } result_t;

endpackage

[hw/rtl/image_row_column_sum_checker_unit.sv]
// Row and column projection sums of an RGB image with range and row checks.
// Requests enter on req_valid/req_ready with kind, red, green, blue,
// expected_row_total and column_index: a pixel in raster order, a column
// total readback, or an end-of-image marker. Results leave on
// res_valid/res_ready as status, total and row_number. Only pixels that end
// a row, pixels that are rejected, readbacks and end markers yield a result.
// Configuration is to be written over the APB port only while the block is
// idle; the block itself does not enforce this. One request is taken every
// cycle while req_ready is high. Each request is registered in the column
// store read stage; its result, if any, then goes to a four-entry result
// queue. The column store sets the rate with one read and one write per
// cycle; a write to the column read in the same cycle is forwarded.
// When the receiver stalls, the queue fills and req_ready drops once the
// queue and the store stage hold four requests; it rises again as results
// are taken. Reset restores the register defaults, clears positions, row
// total and error flag, and empties the column store through a fill count.
module image_row_column_sum_checker_unit
    import ircs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [1:0]          kind,
    input  logic [COMP_W-1:0]   red,
    input  logic [COMP_W-1:0]   green,
    input  logic [COMP_W-1:0]   blue,
    input  logic [TOTAL_W-1:0]  expected_row_total,
    input  logic [COL_W-1:0]    column_index,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [2:0]          status,
    output logic [TOTAL_W-1:0]  total,
    output logic [COL_W-1:0]    row_number
);

    logic [DIM_W-1:0]   image_width_reg;
    logic [DIM_W-1:0]   image_height_reg;
    logic [COMP_W-1:0]  max_value_reg;
    logic               check_rows_reg;

    logic [TOTAL_W-1:0] row_acc_reg, row_acc_next;
    logic [COL_W-1:0]   col_pos_reg, col_pos_next;
    logic [ROW_W-1:0]   row_pos_reg, row_pos_next;
    logic               error_reg, error_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;

    logic [TOTAL_W-1:0] col_mem [MAX_WIDTH];
    logic [TOTAL_W-1:0] rd_data_reg;
    logic [COL_W-1:0]   rd_addr;

    logic               s1_valid_reg;
    logic               s1_wr_reg, s1_wr_next;
    logic               s1_first_reg, s1_first_next;
    logic               s1_known_reg, s1_known_next;
    logic               s1_colread_reg, s1_colread_next;
    logic               s1_has_res_reg, s1_has_res_next;
    logic [COL_W-1:0]   s1_addr_reg;
    logic [SUM_W-1:0]   s1_sum_reg;
    result_t            s1_res_reg, s1_res_next;

    logic               lastw_valid_reg;
    logic [COL_W-1:0]   lastw_addr_reg;
    logic [TOTAL_W-1:0] lastw_data_reg;

    result_t                fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]  count_reg;

    logic                   accept;
    logic                   cfg_write;
    logic [DIM_W-1:0]       width_eff;
    logic [DIM_W-1:0]       height_eff;
    logic [COMPONENT_BITS-1:0] r_val, g_val, b_val;
    logic [SUM_W-1:0]       pix_sum;
    logic [TOTAL_W:0]       acc_wide;
    logic [TOTAL_W-1:0]     acc_sat;
    logic [TOTAL_W-1:0]     acc_new;
    logic [FILL_W-1:0]      col_plus;
    logic                   out_of_range;

    logic [TOTAL_W-1:0]     old_val;
    logic [TOTAL_W:0]       col_wide;
    logic [TOTAL_W-1:0]     col_new;
    logic                   wr_en;
    logic                   push;
    logic                   pop;
    result_t                push_data;
    result_t                head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = 32'(image_width_reg);
            REG_HEIGHT: prdata = 32'(image_height_reg);
            REG_MAXVAL: prdata = 32'(max_value_reg);
            REG_CHECK:  prdata = 32'(check_rows_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            max_value_reg    <= MAXVAL_RESET;
            check_rows_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_WIDTH:  image_width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: image_height_reg <= pwdata[DIM_W-1:0];
                REG_MAXVAL: max_value_reg    <= pwdata[COMP_W-1:0];
                REG_CHECK:  check_rows_reg   <= pwdata[0];
            endcase
        end
    end

    assign req_ready = ({1'b0, count_reg} + 4'(s1_valid_reg)) < 4'(FIFO_DEPTH);
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        if (image_width_reg == '0)
            width_eff = DIM_W'(1);
        else if (image_width_reg > DIM_W'(MAX_WIDTH))
            width_eff = DIM_W'(MAX_WIDTH);
        else
            width_eff = image_width_reg;

        if (image_height_reg == '0)
            height_eff = DIM_W'(1);
        else if (image_height_reg > DIM_W'(MAX_HEIGHT))
            height_eff = DIM_W'(MAX_HEIGHT);
        else
            height_eff = image_height_reg;
    end

    assign r_val    = red[COMPONENT_BITS-1:0];
    assign g_val    = green[COMPONENT_BITS-1:0];
    assign b_val    = blue[COMPONENT_BITS-1:0];
    assign pix_sum  = SUM_W'(r_val) + SUM_W'(g_val) + SUM_W'(b_val);
    assign acc_wide = {1'b0, row_acc_reg} + (TOTAL_W+1)'(pix_sum);
    assign acc_sat  = acc_wide[TOTAL_W] ? TOTAL_MAX : acc_wide[TOTAL_W-1:0];
    assign acc_new  = (col_pos_reg == '0) ? TOTAL_W'(pix_sum) : acc_sat;
    assign col_plus = {1'b0, col_pos_reg} + FILL_W'(1);
    assign out_of_range = (COMP_W'(r_val) > max_value_reg)
                       || (COMP_W'(g_val) > max_value_reg)
                       || (COMP_W'(b_val) > max_value_reg);
    assign rd_addr = (kind == KIND_READ) ? column_index : col_pos_reg;

    always_comb
    begin
        row_acc_next    = row_acc_reg;
        col_pos_next    = col_pos_reg;
        row_pos_next    = row_pos_reg;
        error_next      = error_reg;
        fill_next       = fill_reg;
        s1_wr_next      = 1'b0;
        s1_first_next   = (row_pos_reg == '0);
        s1_known_next   = ({1'b0, rd_addr} < fill_reg);
        s1_colread_next = 1'b0;
        s1_has_res_next = 1'b0;
        s1_res_next     = '{status: ST_ROW_DONE, total: '0,
                            row_number: row_pos_reg[COL_W-1:0]};
        if (accept)
        begin
            unique case (kind)
                KIND_PIXEL:
                begin
                    if (row_pos_reg >= height_eff)
                    begin
                        error_next             = 1'b1;
                        s1_has_res_next        = 1'b1;
                        s1_res_next.status     = ST_TOO_MANY;
                    end
                    else if (out_of_range)
                    begin
                        error_next             = 1'b1;
                        s1_has_res_next        = 1'b1;
                        s1_res_next.status     = ST_RANGE;
                    end
                    else
                    begin
                        s1_wr_next   = 1'b1;
                        row_acc_next = acc_new;
                        if (col_plus > fill_reg)
                            fill_next = col_plus;
                        if (col_plus >= width_eff)
                        begin
                            s1_has_res_next   = 1'b1;
                            s1_res_next.total = acc_new;
                            if (check_rows_reg && (acc_new != expected_row_total))
                            begin
                                s1_res_next.status = ST_ROW_MISMATCH;
                                error_next         = 1'b1;
                            end
                            col_pos_next = '0;
                            row_pos_next = row_pos_reg + ROW_W'(1);
                        end
                        else
                        begin
                            col_pos_next = col_plus[COL_W-1:0];
                        end
                    end
                end
                KIND_READ:
                begin
                    s1_has_res_next = 1'b1;
                    s1_colread_next = 1'b1;
                end
                KIND_END:
                begin
                    s1_has_res_next = 1'b1;
                    if ((row_pos_reg == height_eff) && (col_pos_reg == '0) && !error_reg)
                        s1_res_next.status = ST_IMAGE_OK;
                    else
                        s1_res_next.status = ST_IMAGE_BAD;
                    row_pos_next = '0;
                    col_pos_next = '0;
                    row_acc_next = '0;
                    error_next   = 1'b0;
                end
                KIND_NONE:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (!s1_known_reg)
            old_val = '0;
        else if (lastw_valid_reg && (lastw_addr_reg == s1_addr_reg))
            old_val = lastw_data_reg;
        else
            old_val = rd_data_reg;
    end

    assign col_wide = {1'b0, old_val} + (TOTAL_W+1)'(s1_sum_reg);
    assign col_new  = s1_first_reg ? TOTAL_W'(s1_sum_reg)
                    : (col_wide[TOTAL_W] ? TOTAL_MAX : col_wide[TOTAL_W-1:0]);
    assign wr_en    = s1_valid_reg && s1_wr_reg;

    always_comb
    begin
        push_data = s1_res_reg;
        if (s1_colread_reg)
        begin
            push_data.status     = ST_COLUMN;
            push_data.total      = old_val;
            push_data.row_number = '0;
        end
    end

    assign push = s1_valid_reg && s1_has_res_reg;
    assign pop  = res_valid && res_ready;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= col_mem[rd_addr];
        if (wr_en)
            col_mem[s1_addr_reg] <= col_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_acc_reg     <= '0;
            col_pos_reg     <= '0;
            row_pos_reg     <= '0;
            error_reg       <= 1'b0;
            fill_reg        <= '0;
            s1_valid_reg    <= 1'b0;
            s1_wr_reg       <= 1'b0;
            s1_has_res_reg  <= 1'b0;
            s1_colread_reg  <= 1'b0;
            s1_known_reg    <= 1'b0;
            s1_first_reg    <= 1'b0;
            lastw_valid_reg <= 1'b0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            row_acc_reg     <= row_acc_next;
            col_pos_reg     <= col_pos_next;
            row_pos_reg     <= row_pos_next;
            error_reg       <= error_next;
            fill_reg        <= fill_next;
            s1_valid_reg    <= accept;
            s1_wr_reg       <= s1_wr_next;
            s1_has_res_reg  <= s1_has_res_next;
            s1_colread_reg  <= s1_colread_next;
            s1_known_reg    <= s1_known_next;
            s1_first_reg    <= s1_first_next;
            lastw_valid_reg <= wr_en;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            count_reg <= count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg    <= rd_addr;
        s1_sum_reg     <= pix_sum;
        s1_res_reg     <= s1_res_next;
        lastw_addr_reg <= s1_addr_reg;
        lastw_data_reg <= col_new;
        if (push)
            fifo_mem[wr_ptr_reg] <= push_data;
    end

    assign head       = fifo_mem[rd_ptr_reg];
    assign res_valid  = (count_reg != '0);
    assign status     = head.status;
    assign total      = head.total;
    assign row_number = head.row_number;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import ircs_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_TARGET = 1900;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [1:0]         kind;
        logic [COMP_W-1:0]  red;
        logic [COMP_W-1:0]  green;
        logic [COMP_W-1:0]  blue;
        logic [TOTAL_W-1:0] expected_total;
        logic [COL_W-1:0]   column;
    } pixel_req_t;

    typedef struct packed {
        pixel_req_t req;
        logic       typed;
        logic       has_result;
        result_t    result;
    } directed_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [3:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic [1:0]          kind = '0;
    logic [COMP_W-1:0]   red = '0;
    logic [COMP_W-1:0]   green = '0;
    logic [COMP_W-1:0]   blue = '0;
    logic [TOTAL_W-1:0]  expected_row_total = '0;
    logic [COL_W-1:0]    column_index = '0;
    logic                res_valid;
    logic                res_ready = 1'b0;
    logic [2:0]          status;
    logic [TOTAL_W-1:0]  total;
    logic [COL_W-1:0]    row_number;

    logic [DIM_W-1:0]    cfg_width;
    logic [DIM_W-1:0]    cfg_height;
    logic [COMP_W-1:0]   cfg_max;
    logic                cfg_check;
    logic [TOTAL_W-1:0]  column_sums [MAX_WIDTH];
    logic [TOTAL_W-1:0]  row_sum;
    logic [COL_W-1:0]    col_pos;
    logic [ROW_W-1:0]    row_pos;
    logic                image_error;

    result_t             expected_results [$];
    result_t             oldest;
    directed_row_t       directed_rows [$];
    int                  mismatch_count = 0;
    int                  random_requests = 0;
    int                  cycle_count = 0;
    int                  send_idle = 0;
    int                  recv_stall = 0;

    image_row_column_sum_checker_unit uut (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending: status %0d total %0d row %0d",
                                          status, total, row_number));
            end
            else
            begin
                oldest = expected_results.pop_front();
                if (status !== oldest.status)
                    report_mismatch($sformatf("status %0d, expected %0d", status, oldest.status));
                if (total !== oldest.total)
                    report_mismatch($sformatf("total %0d, expected %0d", total, oldest.total));
                if (row_number !== oldest.row_number)
                    report_mismatch($sformatf("row_number %0d, expected %0d",
                                              row_number, oldest.row_number));
            end
        end
        res_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int top);
        if (v == 0)
            return 1;
        return (v > top) ? top : int'(v);
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [TOTAL_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
    endfunction

    function automatic result_t make_result(input logic [2:0] st, input logic [TOTAL_W-1:0] tot,
                                            input logic [COL_W-1:0] row);
        result_t res;
        res.status = st;
        res.total = tot;
        res.row_number = row;
        return res;
    endfunction

    function automatic void reset_projection();
        cfg_width = WIDTH_RESET;
        cfg_height = HEIGHT_RESET;
        cfg_max = MAXVAL_RESET;
        cfg_check = 1'b0;
        for (int i = 0; i < MAX_WIDTH; i++)
            column_sums[i] = '0;
        row_sum = '0;
        col_pos = '0;
        row_pos = '0;
        image_error = 1'b0;
    endfunction

    function automatic bit project_request(input pixel_req_t r, output result_t res);
        int width;
        int height;
        int col;
        logic [SUM_W-1:0] sum;
        width = clamp_dim(cfg_width, MAX_WIDTH);
        height = clamp_dim(cfg_height, MAX_HEIGHT);
        res = '0;
        if (r.kind == KIND_PIXEL)
        begin
            if (row_pos >= height)
            begin
                image_error = 1'b1;
                res = make_result(ST_TOO_MANY, '0, row_pos[COL_W-1:0]);
                return 1'b1;
            end
            if (r.red > cfg_max || r.green > cfg_max || r.blue > cfg_max)
            begin
                image_error = 1'b1;
                res = make_result(ST_RANGE, '0, row_pos[COL_W-1:0]);
                return 1'b1;
            end
            sum = SUM_W'(r.red) + SUM_W'(r.green) + SUM_W'(r.blue);
            col = int'(col_pos);
            if (row_pos == 0)
                column_sums[col] = TOTAL_W'(sum);
            else
                column_sums[col] = sat_add(column_sums[col], TOTAL_W'(sum));
            row_sum = (col == 0) ? TOTAL_W'(sum) : sat_add(row_sum, TOTAL_W'(sum));
            if (col + 1 >= width)
            begin
                if (cfg_check && row_sum != r.expected_total)
                begin
                    image_error = 1'b1;
                    res = make_result(ST_ROW_MISMATCH, row_sum, row_pos[COL_W-1:0]);
                end
                else
                begin
                    res = make_result(ST_ROW_DONE, row_sum, row_pos[COL_W-1:0]);
                end
                col_pos = '0;
                row_pos = row_pos + ROW_W'(1);
                return 1'b1;
            end
            col_pos = col_pos + COL_W'(1);
            return 1'b0;
        end
        if (r.kind == KIND_READ)
        begin
            res = make_result(ST_COLUMN, column_sums[r.column], '0);
            return 1'b1;
        end
        if (r.kind == KIND_END)
        begin
            res = make_result((row_pos == height && col_pos == 0 && !image_error) ?
                              ST_IMAGE_OK : ST_IMAGE_BAD, '0, row_pos[COL_W-1:0]);
            row_pos = '0;
            col_pos = '0;
            row_sum = '0;
            image_error = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Mostly in-range pixels that carry the correct row total, mixed with readbacks,
    // early image ends, rejected pixels, ignored kinds and raw random requests.
    function automatic pixel_req_t make_request();
        pixel_req_t r;
        int pick;
        int width;
        int height;
        logic [SUM_W-1:0] sum;
        width = clamp_dim(cfg_width, MAX_WIDTH);
        height = clamp_dim(cfg_height, MAX_HEIGHT);
        r.kind = KIND_PIXEL;
        r.red = COMP_W'($urandom_range(0, cfg_max));
        r.green = COMP_W'($urandom_range(0, cfg_max));
        r.blue = COMP_W'($urandom_range(0, cfg_max));
        r.column = COL_W'($urandom_range(0, MAX_WIDTH - 1));
        sum = SUM_W'(r.red) + SUM_W'(r.green) + SUM_W'(r.blue);
        r.expected_total = (col_pos == 0) ? TOTAL_W'(sum) : sat_add(row_sum, TOTAL_W'(sum));
        if ($urandom_range(0, 9) == 0)
            r.expected_total = TOTAL_W'($urandom);
        pick = $urandom_range(0, 99);
        if (row_pos >= height && pick < 85)
        begin
            r.kind = KIND_END;
        end
        else if (pick >= 95)
        begin
            r.red = COMP_W'($urandom);
            r.green = COMP_W'($urandom);
            r.blue = COMP_W'($urandom);
            r.expected_total = TOTAL_W'($urandom);
        end
        else if (pick >= 93)
        begin
            r.kind = KIND_NONE;
            r.red = COMP_W'($urandom);
            r.expected_total = TOTAL_W'($urandom);
        end
        else if (pick >= 90)
        begin
            r.kind = KIND_END;
        end
        else if (pick >= 84)
        begin
            r.kind = KIND_READ;
            if ($urandom_range(0, 1))
                r.column = COL_W'($urandom_range(0, width - 1));
        end
        else if (pick >= 78 && cfg_max != '1)
        begin
            case ($urandom_range(0, 2))
                0: r.red = COMP_W'($urandom_range(cfg_max + 1, 65535));
                1: r.green = COMP_W'($urandom_range(cfg_max + 1, 65535));
                default: r.blue = COMP_W'($urandom_range(cfg_max + 1, 65535));
            endcase
        end
        return r;
    endfunction

    function automatic void add_row(input logic [1:0] k, input int rd, input int gr, input int bl,
                                    input int want_total, input int idx, input bit typed,
                                    input bit has, input logic [2:0] st, input int tot,
                                    input int row);
        directed_row_t d;
        d.req.kind = k;
        d.req.red = COMP_W'(rd);
        d.req.green = COMP_W'(gr);
        d.req.blue = COMP_W'(bl);
        d.req.expected_total = TOTAL_W'(want_total);
        d.req.column = COL_W'(idx);
        d.typed = typed;
        d.has_result = has;
        d.result = make_result(st, TOTAL_W'(tot), COL_W'(row));
        directed_rows.push_back(d);
    endfunction

    task automatic send_request(input pixel_req_t r);
        if ($urandom_range(0, 99) < send_idle)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
        end
        req_valid <= 1'b1;
        kind <= r.kind;
        red <= r.red;
        green <= r.green;
        blue <= r.blue;
        expected_row_total <= r.expected_total;
        column_index <= r.column;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic issue_request(input pixel_req_t r);
        result_t res;
        send_request(r);
        if (project_request(r, res))
            expected_results.push_back(res);
        if (r.kind != KIND_NONE)
            random_requests++;
    endtask

    task automatic drain_results(input int extra);
        req_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (index)
            REG_WIDTH:  cfg_width = value[DIM_W-1:0];
            REG_HEIGHT: cfg_height = value[DIM_W-1:0];
            REG_MAXVAL: cfg_max = value[COMP_W-1:0];
            default:    cfg_check = value[0];
        endcase
    endtask

    task automatic write_config(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input logic [COMP_W-1:0] m, input logic c);
        write_register(REG_WIDTH, 32'(w));
        write_register(REG_HEIGHT, 32'(h));
        write_register(REG_MAXVAL, 32'(m));
        write_register(REG_CHECK, 32'(c));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input int phase);
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [COMP_W-1:0] m;
        int steps;
        pixel_req_t r;
        drain_results(SETTLE_CYCLES);
        case (phase % 4)
            0:
            begin
                send_idle = 0;
                recv_stall = 0;
            end
            1:
            begin
                send_idle = 63;
                recv_stall = 0;
            end
            2:
            begin
                send_idle = 0;
                recv_stall = 63;
            end
            default:
            begin
                send_idle = 9;
                recv_stall = 9;
            end
        endcase
        if (phase == 2)
        begin
            // One full-width row with unrestricted components.
            write_config(11'd2047, 11'd1, 16'hFFFF, 1'b1);
            r = make_request();
            r.kind = KIND_END;
            issue_request(r);
            while (row_pos == 0)
            begin
                r = make_request();
                r.kind = KIND_PIXEL;
                issue_request(r);
            end
            r.kind = KIND_END;
            issue_request(r);
            return;
        end
        case ($urandom_range(0, 19))
            0: w = '0;
            1: w = 11'd1;
            2: w = DIM_W'($urandom_range(MAX_WIDTH + 1, 2047));
            default: w = DIM_W'($urandom_range(2, 12));
        endcase
        case ($urandom_range(0, 19))
            0: h = '0;
            1: h = DIM_W'($urandom_range(MAX_HEIGHT + 1, 2047));
            2: h = DIM_W'(MAX_HEIGHT);
            default: h = DIM_W'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 9))
            0: m = 16'd1;
            1, 2, 3, 4, 5: m = 16'hFFFF;
            6, 7: m = 16'd255;
            default: m = COMP_W'($urandom_range(1, 65535));
        endcase
        write_config(w, h, m, 1'($urandom_range(0, 1)));
        steps = $urandom_range(30, 90);
        for (int i = 0; i < steps; i++)
        begin
            if ((phase == 1 && i == steps / 2) || $urandom_range(0, 63) == 0)
                drain_results(0);
            issue_request(make_request());
        end
    endtask

    initial
    begin
        result_t res;
        bit has;
        int phase;
        reset_projection();
        add_row(KIND_READ, 0, 0, 0, 0, 0, 1, 1, ST_COLUMN, 0, 0);
        add_row(KIND_READ, 0, 0, 0, 0, 1023, 1, 1, ST_COLUMN, 0, 0);
        add_row(KIND_END, 0, 0, 0, 0, 0, 1, 1, ST_IMAGE_BAD, 0, 0);
        add_row(KIND_PIXEL, 256, 0, 0, 0, 0, 1, 1, ST_RANGE, 0, 0);
        add_row(KIND_PIXEL, 0, 65535, 0, 0, 0, 1, 1, ST_RANGE, 0, 0);
        add_row(KIND_PIXEL, 0, 0, 256, 0, 0, 1, 1, ST_RANGE, 0, 0);
        add_row(KIND_END, 0, 0, 0, 0, 0, 1, 1, ST_IMAGE_BAD, 0, 0);
        add_row(KIND_PIXEL, 255, 255, 255, 0, 0, 1, 0, ST_ROW_DONE, 0, 0);
        add_row(KIND_PIXEL, 255, 255, 255, 1530, 0, 1, 1, ST_ROW_DONE, 1530, 0);
        add_row(KIND_PIXEL, 0, 0, 0, 0, 0, 1, 1, ST_TOO_MANY, 0, 1);
        add_row(KIND_END, 0, 0, 0, 0, 0, 1, 1, ST_IMAGE_BAD, 0, 1);
        add_row(KIND_READ, 0, 0, 0, 0, 0, 1, 1, ST_COLUMN, 765, 0);
        add_row(KIND_READ, 0, 0, 0, 0, 1, 1, 1, ST_COLUMN, 765, 0);
        add_row(KIND_PIXEL, 0, 0, 0, 0, 0, 1, 0, ST_ROW_DONE, 0, 0);
        add_row(KIND_PIXEL, 1, 0, 0, 5, 0, 1, 1, ST_ROW_MISMATCH, 1, 0);
        add_row(KIND_END, 0, 0, 0, 0, 0, 1, 1, ST_IMAGE_BAD, 0, 1);
        add_row(KIND_PIXEL, 10, 20, 30, 0, 0, 0, 0, ST_ROW_DONE, 0, 0);
        add_row(KIND_PIXEL, 0, 0, 0, 60, 0, 0, 0, ST_ROW_DONE, 0, 0);
        add_row(KIND_END, 0, 0, 0, 0, 0, 1, 1, ST_IMAGE_OK, 0, 1);
        add_row(KIND_NONE, 65535, 65535, 65535, 268435455, 1023, 1, 0, ST_ROW_DONE, 0, 0);
        add_row(KIND_READ, 0, 0, 0, 0, 0, 1, 1, ST_COLUMN, 60, 0);
        add_row(KIND_PIXEL, 0, 255, 0, 0, 0, 1, 0, ST_ROW_DONE, 0, 0);
        add_row(KIND_END, 0, 0, 0, 0, 0, 1, 1, ST_IMAGE_BAD, 0, 0);
        add_row(KIND_PIXEL, 65535, 65535, 65535, 0, 0, 1, 1, ST_RANGE, 0, 0);
        add_row(KIND_READ, 0, 0, 0, 0, 1, 1, 1, ST_COLUMN, 0, 0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        write_config(11'd2, 11'd1, 16'd255, 1'b1);
        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].req);
            has = project_request(directed_rows[i].req, res);
            if (directed_rows[i].typed)
            begin
                if (directed_rows[i].has_result)
                    expected_results.push_back(directed_rows[i].result);
            end
            else if (has)
            begin
                expected_results.push_back(res);
            end
        end

        phase = 0;
        while (random_requests < RANDOM_TARGET)
        begin
            run_phase(phase);
            phase++;
        end
        drain_results(SETTLE_CYCLES);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
